// ===== rtl/core/clfs_pkg.sv =====
// Shared constants, payload and control types for the cursor list block.
package clfs_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOTS    = CAPACITY + 2;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VALUE_W  = 64;

  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] FREE_SLOT = SLOT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(CAPACITY - 1);

  // Operation codes.
  localparam logic [1:0] FN_MOVE  = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_DEL   = 2'd2;
  localparam logic [1:0] FN_PRINT = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Link memory read address selection.
  localparam logic [2:0] RA_HEAD = 3'd0;
  localparam logic [2:0] RA_FREE = 3'd1;
  localparam logic [2:0] RA_CUR  = 3'd2;
  localparam logic [2:0] RA_RD   = 3'd3;
  localparam logic [2:0] RA_VICT = 3'd4;

  // Link memory write address selection.
  localparam logic [1:0] WA_FREE = 2'd0;
  localparam logic [1:0] WA_CUR  = 2'd1;
  localparam logic [1:0] WA_A    = 2'd2;
  localparam logic [1:0] WA_B    = 2'd3;

  // Link memory write data selection.
  localparam logic [1:0] WD_RD = 2'd0;
  localparam logic [1:0] WD_A  = 2'd1;
  localparam logic [1:0] WD_B  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] item_value;
    logic               is_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] ra_sel;
    logic       wr_en;
    logic [1:0] wa_sel;
    logic [1:0] wd_sel;
    logic       val_we;
    logic       val_ld;
    logic       a_ld;
    logic       b_ld;
    logic       cur_ld;
    logic       cur_wrap;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       emit;
    logic [1:0] status;
    logic       print;
  } clfs_cmd_t;

  typedef struct packed {
    logic rd_is_head;
    logic rd_is_free;
    logic print_last;
  } clfs_sts_t;

  // Link contents after reset: empty value list, free slots chained in a circle.
  function automatic logic [SLOT_W-1:0] link_init(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == HEAD_SLOT) begin
      res = HEAD_SLOT;
    end else if (slot == SLOT_W'(SLOTS - 1)) begin
      res = FREE_SLOT;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/cursor_list_with_free_slots_core.sv =====
// Top level of the array-backed cursor list with a circular free-slot list.
//
//   Channel   Ports                    Handshake
//   --------  -----------------------  ----------------------------------------
//   command   start, busy, in_data     transfer when start is high, busy low
//   result    out_valid, out_data      transfer in every cycle out_valid is high
//
// After the accepting idle cycle, an add with no free slot reports full, a delete or
// print on an empty list reports empty, and a print gives one result per stored value.
// Each result shows in the cycle after the state that produced it. The link memory has
// one read and one write port; each link write stores the last read or a saved slot.
// Reset is synchronous and active low; it clears the cursor, the state and the
// link valid bits, so no clearing pass runs. The receiver cannot stall results.
module cursor_list_with_free_slots_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  clfs_pkg::in_item_t  in_data,
  output logic                out_valid,
  output clfs_pkg::out_item_t out_data
);

  clfs_pkg::clfs_cmd_t cmd;
  clfs_pkg::clfs_sts_t sts;

  // The sequencer decides the order of memory accesses and branches on status.
  clfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the memories and registers and forms every result.
  clfs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_data.value),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Results only follow a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without preceding work");

  // The final result of a command coincides with the block going idle.
  a_last_matches_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_last == !busy))
    else $error("is_last does not match end of command");
`endif

endmodule

// ===== rtl/core/clfs_ram.sv =====
// Generic single write port RAM with one registered read port.
module clfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/clfs_ctrl.sv =====
// Sequencer that steps each operation through the link memory accesses.
module clfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          func,
  input  clfs_pkg::clfs_sts_t sts,
  output logic                busy,
  output clfs_pkg::clfs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOVE = 4'd1;
  localparam logic [3:0] S_ADD1 = 4'd2;
  localparam logic [3:0] S_ADD2 = 4'd3;
  localparam logic [3:0] S_ADD3 = 4'd4;
  localparam logic [3:0] S_ADD4 = 4'd5;
  localparam logic [3:0] S_DEL1 = 4'd6;
  localparam logic [3:0] S_DEL2 = 4'd7;
  localparam logic [3:0] S_DEL3 = 4'd8;
  localparam logic [3:0] S_DEL4 = 4'd9;
  localparam logic [3:0] S_DEL5 = 4'd10;
  localparam logic [3:0] S_PRT1 = 4'd11;
  localparam logic [3:0] S_PRT2 = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        // The first link read is issued while waiting, so it is ready on entry.
        case (func)
          clfs_pkg::FN_MOVE: cmd.ra_sel = clfs_pkg::RA_CUR;
          clfs_pkg::FN_ADD:  cmd.ra_sel = clfs_pkg::RA_FREE;
          default:           cmd.ra_sel = clfs_pkg::RA_HEAD;
        endcase
        cmd.val_ld = accept;
        if (accept) begin
          case (func)
            clfs_pkg::FN_MOVE: state_nxt = S_MOVE;
            clfs_pkg::FN_ADD:  state_nxt = S_ADD1;
            clfs_pkg::FN_DEL:  state_nxt = S_DEL1;
            default:           state_nxt = S_PRT1;
          endcase
        end
      end
      S_MOVE: begin
        cmd.cur_ld = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = clfs_pkg::ST_OK;
        state_nxt  = S_IDLE;
      end
      S_ADD1: begin
        if (sts.rd_is_free) begin
          cmd.emit   = 1'b1;
          cmd.status = clfs_pkg::ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          cmd.a_ld   = 1'b1;
          cmd.ra_sel = clfs_pkg::RA_RD;
          state_nxt  = S_ADD2;
        end
      end
      S_ADD2: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_FREE;
        cmd.wd_sel = clfs_pkg::WD_RD;
        cmd.ra_sel = clfs_pkg::RA_CUR;
        state_nxt  = S_ADD3;
      end
      S_ADD3: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_A;
        cmd.wd_sel = clfs_pkg::WD_RD;
        state_nxt  = S_ADD4;
      end
      S_ADD4: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_CUR;
        cmd.wd_sel = clfs_pkg::WD_A;
        cmd.val_we = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = clfs_pkg::ST_OK;
        state_nxt  = S_IDLE;
      end
      S_DEL1: begin
        if (sts.rd_is_head) begin
          cmd.emit   = 1'b1;
          cmd.status = clfs_pkg::ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.a_ld   = 1'b1;
          cmd.ra_sel = clfs_pkg::RA_CUR;
          state_nxt  = S_DEL2;
        end
      end
      S_DEL2: begin
        cmd.b_ld     = 1'b1;
        cmd.cur_wrap = 1'b1;
        cmd.ra_sel   = clfs_pkg::RA_VICT;
        state_nxt    = S_DEL3;
      end
      S_DEL3: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_CUR;
        cmd.wd_sel = clfs_pkg::WD_RD;
        cmd.ra_sel = clfs_pkg::RA_FREE;
        state_nxt  = S_DEL4;
      end
      S_DEL4: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_B;
        cmd.wd_sel = clfs_pkg::WD_RD;
        state_nxt  = S_DEL5;
      end
      S_DEL5: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = clfs_pkg::WA_FREE;
        cmd.wd_sel = clfs_pkg::WD_B;
        cmd.emit   = 1'b1;
        cmd.status = clfs_pkg::ST_OK;
        state_nxt  = S_IDLE;
      end
      S_PRT1: begin
        if (sts.rd_is_head) begin
          cmd.emit   = 1'b1;
          cmd.status = clfs_pkg::ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.a_ld    = 1'b1;
          cmd.cnt_clr = 1'b1;
          cmd.ra_sel  = clfs_pkg::RA_RD;
          state_nxt   = S_PRT2;
        end
      end
      S_PRT2: begin
        cmd.emit   = 1'b1;
        cmd.print  = 1'b1;
        cmd.status = clfs_pkg::ST_OK;
        if (sts.print_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.a_ld    = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.ra_sel  = clfs_pkg::RA_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/clfs_dpath.sv =====
// Link and value memories, cursor and slot registers, and the result register.
module clfs_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clfs_pkg::clfs_cmd_t           cmd,
  input  logic [clfs_pkg::VALUE_W-1:0]  in_value,
  output clfs_pkg::clfs_sts_t           sts,
  output logic                          out_valid,
  output clfs_pkg::out_item_t           out_data
);

  localparam int SW = clfs_pkg::SLOT_W;

  logic [SW-1:0]                 cur_r, a_r, b_r;
  logic [clfs_pkg::CNT_W-1:0]    cnt_r;
  logic [clfs_pkg::VALUE_W-1:0]  val_r;
  logic [clfs_pkg::SLOTS-1:0]    vld_r;
  logic                          vld_q_r;
  logic [SW-1:0]                 raddr_q_r;
  logic [SW-1:0]                 lk_raddr, lk_waddr, lk_wdata, lk_ram_q, link_rd, victim;
  logic [clfs_pkg::VALUE_W-1:0]  val_rd;
  logic                          out_valid_r;
  clfs_pkg::out_item_t           out_data_r, out_nxt;

  // Entries never written still hold their reset links.
  assign link_rd = vld_q_r ? lk_ram_q : clfs_pkg::link_init(raddr_q_r);
  assign victim  = (link_rd == clfs_pkg::HEAD_SLOT) ? a_r : link_rd;

  always_comb begin
    case (cmd.ra_sel)
      clfs_pkg::RA_FREE: lk_raddr = clfs_pkg::FREE_SLOT;
      clfs_pkg::RA_CUR:  lk_raddr = cur_r;
      clfs_pkg::RA_RD:   lk_raddr = link_rd;
      clfs_pkg::RA_VICT: lk_raddr = victim;
      default:           lk_raddr = clfs_pkg::HEAD_SLOT;
    endcase
    case (cmd.wa_sel)
      clfs_pkg::WA_CUR: lk_waddr = cur_r;
      clfs_pkg::WA_A:   lk_waddr = a_r;
      clfs_pkg::WA_B:   lk_waddr = b_r;
      default:          lk_waddr = clfs_pkg::FREE_SLOT;
    endcase
    case (cmd.wd_sel)
      clfs_pkg::WD_A: lk_wdata = a_r;
      clfs_pkg::WD_B: lk_wdata = b_r;
      default:        lk_wdata = link_rd;
    endcase
  end

  clfs_ram #(.WIDTH(SW), .DEPTH(clfs_pkg::SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_ram_q)
  );

  clfs_ram #(.WIDTH(clfs_pkg::VALUE_W), .DEPTH(clfs_pkg::SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (cmd.val_we),
    .waddr (a_r),
    .wdata (val_r),
    .raddr (lk_raddr),
    .rdata (val_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
      cur_r   <= clfs_pkg::HEAD_SLOT;
    end else begin
      vld_q_r <= vld_r[lk_raddr];
      if (cmd.wr_en) begin
        vld_r[lk_waddr] <= 1'b1;
      end
      if (cmd.cur_ld) begin
        cur_r <= link_rd;
      end else if (cmd.cur_wrap && (link_rd == clfs_pkg::HEAD_SLOT)) begin
        cur_r <= clfs_pkg::HEAD_SLOT;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= lk_raddr;
    if (cmd.val_ld) begin
      val_r <= in_value;
    end
    if (cmd.a_ld) begin
      a_r <= link_rd;
    end
    if (cmd.b_ld) begin
      b_r <= victim;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + clfs_pkg::CNT_W'(1);
    end
  end

  assign sts.rd_is_head = (link_rd == clfs_pkg::HEAD_SLOT);
  assign sts.rd_is_free = (link_rd == clfs_pkg::FREE_SLOT);
  assign sts.print_last = (link_rd == clfs_pkg::HEAD_SLOT) || (cnt_r == clfs_pkg::CNT_LAST);

  always_comb begin
    out_nxt.status     = cmd.status;
    out_nxt.item_value = cmd.print ? val_rd : '0;
    out_nxt.is_last    = cmd.print ? sts.print_last : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
